>>> rtl/bounded_set_table_core_defines.svh
// Assertion macros used by the file that checks its own logic.
`ifndef BOUNDED_SET_TABLE_CORE_DEFINES_SVH
`define BOUNDED_SET_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BST_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BST_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bst_pkg.sv
package bst_pkg;

    localparam int CAPACITY_DEF = 8;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [POS_W-1:0] pos;
    } t_cell_ctl;

endpackage

>>> rtl/bst_cell.sv
// One slot of the table. It compares its entry against the request value
// and either keeps its entry, takes the new value, or takes its upper
// neighbor's entry when a remove closes the gap below it.
module bst_cell import bst_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 4
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_count,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [VALUE_W-1:0] i_next,
    output logic [VALUE_W-1:0] o_data,
    output logic               o_hit
);

    localparam logic [31:0] MY_IDX  = 32'(IDX);
    localparam logic [31:0] NXT_IDX = 32'(IDX + 1);

    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;
    logic [31:0]        cnt32;
    logic [31:0]        pos32;
    logic               take_new;
    logic               take_next;

    assign cnt32 = 32'(i_count);
    assign pos32 = 32'(i_ctl.pos);

    assign take_new  = i_ctl.ins && (MY_IDX == cnt32);
    assign take_next = i_ctl.rem && (MY_IDX >= pos32) && (NXT_IDX < cnt32);

    always_comb begin
        if (take_new) begin
            n_data = i_value;
        end else if (take_next) begin
            n_data = i_next;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (MY_IDX < cnt32) && (r_data == i_value);

endmodule

>>> rtl/bounded_set_table_core.sv
// Bounded set table: a packed table of up to CAPACITY distinct signed
// 32-bit values and their count. Each request on the input stream is a
// query, an insert or a remove by position (command code 3 acts as a
// query), and it produces exactly one response on the output stream with
// the found flag (value present before the request), a status code (done,
// duplicate ignored, table full, position out of range) and the count
// after the request, taken modulo 16. The table is a row of cells, one per
// entry; every cell compares its entry against the request value in
// parallel, and a remove shifts each later entry down by one place in the
// same cycle. Each request gets a registered response, and requests are
// taken back to back; the only thing that holds the input is a response
// still waiting in the output register. Entry contents need no reset,
// since only entries below the count are ever compared or shifted, and
// those were all written first.
module bounded_set_table_core import bst_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [1:0] cmd, [33:2] value, [36:34] position, [39:37] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] found, [2:1] status, [6:3] count, [7] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

`include "bounded_set_table_core_defines.svh"

    // Count width: enough to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    // Request fields.
    logic [CMD_W-1:0]   req_cmd;
    logic [VALUE_W-1:0] req_value;
    logic [POS_W-1:0]   req_pos;

    assign req_cmd   = i_s_axis_tdata[CMD_W-1:0];
    assign req_value = i_s_axis_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign req_pos   = i_s_axis_tdata[CMD_W+VALUE_W+POS_W-1:CMD_W+VALUE_W];

    logic req_acc;
    assign o_s_axis_tready = !o_m_axis_tvalid || i_m_axis_tready;
    assign req_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // Occupancy counter.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // Row of cells.
    logic [VALUE_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    t_cell_ctl           ctl;
    logic                found;

    // Decision for the current request.
    logic [STATUS_W-1:0] n_status;
    logic                do_ins;
    logic                do_rem;
    logic                is_full;
    logic                pos_bad;

    assign found   = |cell_hit;
    assign is_full = (r_count == CW'(CAPACITY));
    assign pos_bad = (32'(req_pos) >= 32'(r_count));

    always_comb begin
        n_status = ST_DONE;
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        case (req_cmd)
            CMD_INSERT: begin
                if (found) begin
                    n_status = ST_DUP;
                end else if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (pos_bad) begin
                    n_status = ST_RANGE;
                end else begin
                    do_rem = 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Cells only see a change when the request is actually accepted.
    assign ctl.ins = req_acc && do_ins;
    assign ctl.rem = req_acc && do_rem;
    assign ctl.pos = req_pos;

    always_comb begin
        if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            // The top cell has no upper neighbor; it never shifts, so it is
            // fed its own entry.
            logic [VALUE_W-1:0] next_data;
            if (g == CAPACITY - 1) begin : g_top
                assign next_data = cell_data[g];
            end else begin : g_mid
                assign next_data = cell_data[g+1];
            end

            bst_cell #(
                .IDX (g),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_count (r_count),
                .i_value (req_value),
                .i_next  (next_data),
                .o_data  (cell_data[g]),
                .o_hit   (cell_hit[g])
            );
        end
    endgenerate

    // Response register.
    logic                r_out_valid;
    logic                r_found;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count_out;
    logic [CW+COUNT_W-1:0] count_ext;

    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (req_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_found     <= found;
            r_status    <= n_status;
            r_count_out <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_count_out, r_status, r_found};

    // The count never runs past the table size.
    `BST_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")

    // A successful insert grows the table by exactly one entry.
    `BST_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, ctl.ins, r_count == $past(r_count) + CW'(1), "insert did not grow count")

    // A duplicate status is only ever reported for a value that was found.
    `BST_ASSERT_NOW(a_dup_found, i_clk, i_rst_n, r_out_valid && (r_status == ST_DUP), r_found, "duplicate without hit")

    // A rejected request leaves the count untouched.
    `BST_ASSERT_NEXT(a_reject_hold, i_clk, i_rst_n, req_acc && (n_status != ST_DONE), r_count == $past(r_count), "rejected request changed count")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

import bst_pkg::*;

// Command code 3 has no name in the package; the block treats it as a query.
localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

// How often one side of the stream waits before an item.
typedef enum int {IDLE_NONE, IDLE_RARE, IDLE_FULL} t_idle_style;

// One response, split into its fields.
typedef struct packed {
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
} t_bst_resp;

// Keeps a shadow copy of the table, predicts the response of every accepted
// request and compares the responses against those predictions in order.
class bst_scoreboard;
    logic [VALUE_W-1:0] slots[CAPACITY_DEF];
    int                 fill;
    t_bst_resp          awaited_responses[$];
    int                 failures;

    function new();
        fill = 0;
        failures = 0;
        foreach (slots[i]) slots[i] = '0;
    endfunction

    function int occupancy();
        return fill;
    endfunction

    function logic [VALUE_W-1:0] stored(int idx);
        return slots[idx];
    endfunction

    function int outstanding();
        return awaited_responses.size();
    endfunction

    // Applies one accepted request to the shadow table and queues the
    // response it must produce.
    function void note_request(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos);
        t_bst_resp resp;
        logic      present;
        present = 1'b0;
        for (int i = 0; i < fill; i++) begin
            if (slots[i] == value) present = 1'b1;
        end
        resp.status = ST_DONE;
        case (cmd)
            CMD_INSERT: begin
                if (present) begin
                    resp.status = ST_DUP;
                end else if (fill >= CAPACITY_DEF) begin
                    resp.status = ST_FULL;
                end else begin
                    slots[fill] = value;
                    fill++;
                end
            end
            CMD_REMOVE: begin
                if (int'(pos) >= fill) begin
                    resp.status = ST_RANGE;
                end else begin
                    for (int i = int'(pos); i + 1 < fill; i++) slots[i] = slots[i + 1];
                    fill--;
                end
            end
            default: begin
                // Queries, and the spare code, leave the table alone.
            end
        endcase
        resp.found = present;
        resp.count = COUNT_W'(fill);
        awaited_responses.push_back(resp);
    endfunction

    function void check_response(logic [OUT_TDATA_W-1:0] word);
        t_bst_resp           want;
        logic                got_found;
        logic [STATUS_W-1:0] got_status;
        logic [COUNT_W-1:0]  got_count;
        got_found  = word[0];
        got_status = word[2:1];
        got_count  = word[6:3];
        if (awaited_responses.size() == 0) begin
            $error("response %h arrived with no request outstanding", word);
            failures++;
            return;
        end
        want = awaited_responses.pop_front();
        if (got_found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, got_found);
            failures++;
        end
        if (got_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got_status);
            failures++;
        end
        if (got_count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, got_count);
            failures++;
        end
    endfunction
endclass

module testbench;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // [1:0] cmd, [33:2] value, [36:34] position, [39:37] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // [0] found, [2:1] status, [6:3] count, [7] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    bst_scoreboard sb = new();

    t_idle_style source_style = IDLE_NONE;
    t_idle_style sink_style   = IDLE_NONE;
    // Set by the stimulus to make the response side hold off for a long time.
    bit          hold_off_req = 1'b0;

    always #5 i_clk = ~i_clk;

    bounded_set_table_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic int draw_wait(t_idle_style style);
        case (style)
            IDLE_NONE: return 0;
            IDLE_RARE: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
            default:   return int'($urandom_range(0, 10));
        endcase
    endfunction

    // Both handshakes are observed at the clock edge, before any of this
    // edge's updates land, so prediction and checking see settled values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                sb.note_request(i_s_axis_tdata[1:0], i_s_axis_tdata[33:2],
                                i_s_axis_tdata[36:34]);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                sb.check_response(o_m_axis_tdata);
            end
        end
    end

    // Response side: a random stall before each response, and one long
    // hold-off on request so the block backs up and stops taking requests.
    initial begin : response_sink
        int stall;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = 400;
            end else begin
                stall = draw_wait(sink_style);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Offers one request after a random gap and returns once it is taken.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = draw_wait(source_style);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, pos, value, cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stops offering and waits until every outstanding response is back.
    // The first edge lets the monitor note the request taken at this edge
    // before the outstanding count is looked at.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random traffic. Values come mostly from a small pool or from the
    // table itself so that hits and duplicates are common; positions are
    // mostly valid. A growing phase favors inserts to reach a full table,
    // a shrinking one favors removes to empty it again.
    task automatic random_phase(input int n_items, input bit growing);
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] pool[10];
        int                 roll;
        int                 fill;
        foreach (pool[k]) pool[k] = $urandom;
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        repeat (n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < (growing ? 55 : 20)) cmd = CMD_INSERT;
            else if (roll < 80)             cmd = CMD_REMOVE;
            else if (roll < 96)             cmd = CMD_QUERY;
            else                            cmd = CMD_SPARE;
            fill = sb.occupancy();
            roll = $urandom_range(0, 99);
            if (roll < 30 && fill > 0) value = sb.stored($urandom_range(0, fill - 1));
            else if (roll < 80)        value = pool[$urandom_range(0, 9)];
            else                       value = $urandom;
            if ($urandom_range(0, 4) != 0 && fill > 0) pos = POS_W'($urandom_range(0, fill - 1));
            else                                       pos = POS_W'($urandom);
            send_request(cmd, value, pos);
        end
    endtask

    initial begin : stimulus
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, extreme values, duplicates, a full
        // table, removes at both ends and in the middle, and the spare code.
        source_style = IDLE_RARE;
        sink_style   = IDLE_RARE;
        send_request(CMD_QUERY,  32'h0000_0000, 3'd0);
        send_request(CMD_REMOVE, 32'h0000_0000, 3'd0);  // empty table, out of range
        send_request(CMD_REMOVE, 32'hFFFF_FFFF, 3'd7);
        send_request(CMD_INSERT, 32'h8000_0000, 3'd0);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 3'd7);
        send_request(CMD_INSERT, 32'h0000_0000, 3'd0);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 3'd0);
        send_request(CMD_INSERT, 32'h8000_0000, 3'd0);  // duplicate
        send_request(CMD_QUERY,  32'h7FFF_FFFF, 3'd0);
        send_request(CMD_QUERY,  32'h0000_0001, 3'd0);
        send_request(CMD_SPARE,  32'h7FFF_FFFF, 3'd5);
        send_request(CMD_INSERT, 32'h0000_0001, 3'd0);
        send_request(CMD_INSERT, 32'h5555_5555, 3'd0);
        send_request(CMD_INSERT, 32'hAAAA_AAAA, 3'd0);
        send_request(CMD_INSERT, 32'h0000_0002, 3'd0);  // table now full
        send_request(CMD_INSERT, 32'h0000_0003, 3'd0);  // full
        send_request(CMD_INSERT, 32'h0000_0000, 3'd0);  // duplicate while full
        send_request(CMD_QUERY,  32'hFFFF_FFFF, 3'd0);
        send_request(CMD_REMOVE, 32'h0000_0000, 3'd7);  // last entry
        send_request(CMD_REMOVE, 32'h0000_0000, 3'd0);  // first entry, all shift
        send_request(CMD_REMOVE, 32'h0000_0000, 3'd7);  // now past the end
        send_request(CMD_REMOVE, 32'h0000_0000, 3'd3);
        send_request(CMD_QUERY,  32'h8000_0000, 3'd0);
        send_request(CMD_SPARE,  32'h0000_0002, 3'd2);
        drain();

        // Random part in phases with different idling on each side. The
        // third phase also asks the response side for a long hold-off while
        // requests keep coming. Each phase ends with the request side paused
        // until all responses are back.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin source_style = IDLE_NONE; sink_style = IDLE_NONE; end
                1: begin source_style = IDLE_FULL; sink_style = IDLE_NONE; end
                2: begin
                    source_style = IDLE_NONE;
                    sink_style   = IDLE_FULL;
                    hold_off_req = 1'b1;
                end
                3: begin source_style = IDLE_FULL; sink_style = IDLE_FULL; end
                4: begin source_style = IDLE_RARE; sink_style = IDLE_RARE; end
                default: begin source_style = IDLE_NONE; sink_style = IDLE_RARE; end
            endcase
            random_phase(150, (p % 2) == 0);
            drain();
        end

        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
